// ===== rtl/modexp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the modular exponentiation block.
// No dependencies; used by modexp_mulmod and modular_exponentiation_top.
package modexp_pkg;

    localparam int BASE_WIDTH    = 64;
    localparam int EXP_WIDTH     = 32;
    localparam int RESULT_WIDTH  = 32;
    localparam int CFG_WIDTH     = 32;
    localparam int CFG_INDEX_W   = 1;
    localparam int DEF_MOD_WIDTH = 32;

    // Bit counter of the serial multiplier must hold BASE_WIDTH itself.
    localparam int CNT_WIDTH = $clog2(BASE_WIDTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b1;

endpackage

// ===== rtl/modexp_mulmod.sv =====
`timescale 1ns / 1ps
// Bit-serial modular multiplier: result = addend * bits mod modulus, MSB first.
// Depends on modexp_pkg.
module modexp_mulmod #(
    parameter int MOD_WIDTH = modexp_pkg::DEF_MOD_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [MOD_WIDTH-1:0]                addend,
    input  logic [modexp_pkg::BASE_WIDTH-1:0]   bits,
    input  logic [modexp_pkg::CNT_WIDTH-1:0]    count,
    input  logic [MOD_WIDTH:0]                  mod_ext,
    output logic                                done,
    output logic [MOD_WIDTH-1:0]                result
);
    import modexp_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   phase_reg, phase_next;
    logic [CNT_WIDTH-1:0]   left_reg, left_next;
    logic [MOD_WIDTH-1:0]   acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]   addend_reg, addend_next;
    logic [BASE_WIDTH-1:0]  bits_reg, bits_next;

    logic [MOD_WIDTH-1:0]   operand;
    logic [MOD_WIDTH:0]     sum;
    logic [MOD_WIDTH+1:0]   diff;
    logic [MOD_WIDTH-1:0]   reduced;

    // One modular add per cycle: doubling in phase 0, adding the addend in phase 1.
    // Both terms are below the modulus, so a single conditional subtract suffices.
    always_comb
    begin
        operand = phase_reg ? addend_reg : acc_reg;
        sum     = {1'b0, acc_reg} + {1'b0, operand};
        diff    = {1'b0, sum} - {1'b0, mod_ext};
        reduced = diff[MOD_WIDTH+1] ? sum[MOD_WIDTH-1:0] : diff[MOD_WIDTH-1:0];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        phase_next  = phase_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        bits_next   = bits_reg;

        if (start)
        begin
            busy_next   = 1'b1;
            phase_next  = 1'b0;
            left_next   = count;
            acc_next    = '0;
            addend_next = addend;
            bits_next   = bits;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                acc_next   = reduced;
                phase_next = 1'b1;
            end
            else
            begin
                if (bits_reg[BASE_WIDTH-1])
                begin
                    acc_next = reduced;
                end
                bits_next  = bits_reg << 1;
                left_next  = left_reg - CNT_WIDTH'(1);
                phase_next = 1'b0;
                if (left_reg == CNT_WIDTH'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        bits_reg   <= bits_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// The base is first reduced modulo the modulus, then each exponent bit up to the highest set
// bit costs one or two modular multiplies. Throughput: one transaction at a time, bounded by
// the single shared bit-serial modular multiplier. The next input is taken while a result waits.
// Reset: exponent 0, modulus 1, no result pending. Depends on modexp_pkg and modexp_mulmod.
module modular_exponentiation_top #(
    parameter int MOD_WIDTH = modexp_pkg::DEF_MOD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [modexp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [modexp_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [modexp_pkg::BASE_WIDTH-1:0]    base_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [modexp_pkg::RESULT_WIDTH-1:0]  power_result
);
    import modexp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_SQR    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam int ALIGN = BASE_WIDTH - MOD_WIDTH;

    logic [2:0]              state_reg, state_next;
    logic [EXP_WIDTH-1:0]    exp_reg, exp_next;
    logic [MOD_WIDTH-1:0]    mod_reg, mod_next;
    logic [EXP_WIDTH-1:0]    e_reg, e_next;
    logic [MOD_WIDTH-1:0]    acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]    b_reg, b_next;
    logic                    out_valid_reg, out_valid_next;
    logic [RESULT_WIDTH-1:0] result_reg, result_next;

    logic [MOD_WIDTH:0]      mod_ext;
    logic                    mm_start;
    logic [MOD_WIDTH-1:0]    mm_addend;
    logic [BASE_WIDTH-1:0]   mm_bits;
    logic [CNT_WIDTH-1:0]    mm_count;
    logic                    mm_done;
    logic [MOD_WIDTH-1:0]    mm_result;

    // A zero modulus means plain wrap-around, which is arithmetic modulo 2^MOD_WIDTH.
    assign mod_ext = (mod_reg == '0) ? {1'b1, {MOD_WIDTH{1'b0}}} : {1'b0, mod_reg};

    modexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .addend  (mm_addend),
        .bits    (mm_bits),
        .count   (mm_count),
        .mod_ext (mod_ext),
        .done    (mm_done),
        .result  (mm_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        mm_start  = 1'b0;
        mm_addend = acc_reg;
        mm_bits   = BASE_WIDTH'(b_reg) << ALIGN;
        mm_count  = CNT_WIDTH'(MOD_WIDTH);

        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_EXPONENT: exp_next = EXP_WIDTH'(cfg_data);
                REG_MODULUS:  mod_next = MOD_WIDTH'(cfg_data);
                default:      ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // The base is reduced as the product 1 * base, one base bit per step.
                    mm_start   = 1'b1;
                    mm_addend  = MOD_WIDTH'(1);
                    mm_bits    = base_value;
                    mm_count   = CNT_WIDTH'(BASE_WIDTH);
                    e_next     = exp_reg;
                    acc_next   = MOD_WIDTH'(1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    b_next     = mm_result;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_addend  = acc_reg;
                    state_next = ST_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_addend  = b_reg;
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_result;
                    e_next     = e_reg & ~EXP_WIDTH'(1);
                    state_next = ST_STEP;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    b_next     = mm_result;
                    e_next     = e_reg >> 1;
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = RESULT_WIDTH'(acc_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            exp_reg       <= '0;
            mod_reg       <= MOD_WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            mod_reg       <= mod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        b_reg      <= b_next;
        result_reg <= result_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;

    // The multiplier only reports completion while the sequencer is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR))
        else $error("multiplier finished while the sequencer was not waiting");

    // An accepted transaction always starts with the base reduction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_REDUCE))
        else $error("accepted transaction did not start the base reduction");

    // A finished result never overwrites one that is still waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && out_stall) |=>
            (state_reg == ST_FINISH && $stable(result_reg)))
        else $error("pending result was overwritten");

    // Each result is presented once: leaving the finish state always raises valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("finished transaction produced no result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation_top: a queue-fed driver and a
// monitor compare every result with a power computed here from the register settings.
// Depends on modexp_pkg and the modular_exponentiation_top RTL.
module testbench;

    import modexp_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 4_000_000;
    localparam int unsigned TAIL_CYCLES  = 5_000;
    localparam int unsigned LONG_HOLD    = 3_000;
    localparam int unsigned REPORT_MAX   = 10;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = REG_EXPONENT;
    logic [CFG_WIDTH-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [BASE_WIDTH-1:0]    base_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [RESULT_WIDTH-1:0]  power_result;

    // Copies of the block's registers, changed only while the block is idle.
    logic [EXP_WIDTH-1:0]     cur_exponent = '0;
    logic [CFG_WIDTH-1:0]     cur_modulus = 32'd1;

    logic [BASE_WIDTH-1:0]    pending_bases[$];
    logic [RESULT_WIDTH-1:0]  expected_powers[$];

    int unsigned              send_idle_pct = 0;
    int unsigned              recv_idle_pct = 0;
    logic                     hold_request = 1'b0;
    int unsigned              hold_left = 0;
    int unsigned              cycle_count = 0;
    int unsigned              error_count = 0;

    modular_exponentiation_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_value   (base_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A modulus of zero means plain 32-bit wrapping arithmetic.
    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] m);
        if (m == 64'd0)
        begin
            return (a * b) & 64'hFFFF_FFFF;
        end
        return (a * b) % m;
    endfunction

    function automatic logic [RESULT_WIDTH-1:0] predict_power(logic [63:0] base,
                                                              logic [31:0] expo,
                                                              logic [31:0] modv);
        logic [63:0] m;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [31:0] e;
        m = {32'd0, modv};
        e = expo;
        acc = 64'd1;
        sq = (m == 64'd0) ? (base & 64'hFFFF_FFFF) : (base % m);
        while (e != 32'd0)
        begin
            if (e[0])
            begin
                acc = mul_reduce(acc, sq, m);
            end
            sq = mul_reduce(sq, sq, m);
            e = e >> 1;
        end
        return acc[31:0];
    endfunction

    // Driver: takes the next base once the previous transaction has been accepted.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            expected_powers.push_back(predict_power(base_value, cur_exponent, cur_modulus));
        end
        if (!in_valid || !in_stall)
        begin
            if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                base_value <= pending_bases.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each accepted result against the oldest outstanding power.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_powers.size() == 0)
            begin
                if (error_count < REPORT_MAX)
                begin
                    $display("result %h arrived with no transaction outstanding",
                             power_result);
                end
                error_count = error_count + 1;
            end
            else
            begin
                if (power_result !== expected_powers[0])
                begin
                    if (error_count < REPORT_MAX)
                    begin
                        $display("power_result mismatch: expected %h, got %h",
                                 expected_powers[0], power_result);
                    end
                    error_count = error_count + 1;
                end
                void'(expected_powers.pop_front());
            end
        end
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Sampled on the falling edge so that every update of the clock edge has settled.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_bases.size() != 0 || in_valid || expected_powers.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_EXPONENT)
        begin
            cur_exponent = data;
        end
        else
        begin
            cur_modulus = data;
        end
    endtask

    task automatic apply_settings(input logic [31:0] expo, input logic [31:0] modv);
        write_reg(REG_EXPONENT, expo);
        write_reg(REG_MODULUS, modv);
    endtask

    initial
    begin
        int unsigned regime;
        int unsigned batch;
        int unsigned k;
        logic [31:0] expo_pick;
        logic [31:0] mod_pick;
        logic [63:0] pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 55;

        // Registers as they come out of reset: zero exponent, modulus one.
        pending_bases.push_back(64'd0);
        pending_bases.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        // Zero exponent gives one whatever the base.
        apply_settings(32'd0, 32'hFFFF_FFFF);
        pending_bases.push_back(64'd5);
        wait_drained();

        // Modulus one with a nonzero exponent gives zero.
        apply_settings(32'hFFFF_FFFF, 32'd1);
        pending_bases.push_back(64'd7);
        pending_bases.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pending_bases.push_back(64'd0);
        pending_bases.push_back(64'd1);
        pending_bases.push_back(64'd2);
        pending_bases.push_back(64'h0000_0000_FFFF_FFFE);
        pending_bases.push_back(64'h0000_0000_FFFF_FFFF);
        pending_bases.push_back(64'h0000_0001_0000_0000);
        pending_bases.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        apply_settings(32'd65537, 32'hFFFF_FFFB);
        pending_bases.push_back(64'd3);
        pending_bases.push_back(64'h0123_4567_89AB_CDEF);
        pending_bases.push_back(64'h0000_0000_FFFF_FFFC);
        wait_drained();

        // A zero modulus wraps the arithmetic at 32 bits.
        apply_settings(32'hFFFF_FFFF, 32'd0);
        pending_bases.push_back(64'd3);
        pending_bases.push_back(64'hFFFF_FFFF_0000_0000);
        pending_bases.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        apply_settings(32'd1, 32'd2);
        pending_bases.push_back(64'd0);
        pending_bases.push_back(64'd1);
        pending_bases.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        for (regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 55;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (batch = 0; batch < 4; batch++)
            begin
                case ($urandom_range(0, 3))
                    0: expo_pick = $urandom;
                    1: expo_pick = $urandom_range(0, 20);
                    2: expo_pick = 32'hFFFF_FFFF;
                    default: expo_pick = $urandom >> $urandom_range(0, 31);
                endcase
                case ($urandom_range(0, 9))
                    0, 1: mod_pick = $urandom;
                    2: mod_pick = $urandom_range(1, 1000);
                    3: mod_pick = 32'hFFFF_FFFF;
                    4: mod_pick = $urandom_range(0, 1);
                    default: mod_pick = $urandom | 32'h8000_0000;
                endcase
                // A short exponent keeps each transaction quick, so the long output
                // hold-off fills the block and pushes back on the input.
                if (regime == 2 && batch == 0)
                begin
                    expo_pick = $urandom_range(2, 7);
                end
                apply_settings(expo_pick, mod_pick);
                wait_drained();
                if (regime == 2 && batch == 0)
                begin
                    hold_request = 1'b1;
                    @(negedge clk);
                    hold_request = 1'b0;
                end
                for (k = 0; k < 10; k++)
                begin
                    case ($urandom_range(0, 4))
                        0: pick = {$urandom, $urandom};
                        1: pick = {32'd0, $urandom};
                        2: pick = {32'd0, mod_pick} + $urandom_range(0, 2) - 64'd1;
                        3: pick = $urandom_range(0, 3);
                        default: pick = {32'hFFFF_FFFF, $urandom};
                    endcase
                    pending_bases.push_back(pick);
                end
                wait_drained();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_powers.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
